>>> hw/rtl/mkht_pkg.sv
// Shared types and constants for the multi-key hold tracker.
// No dependencies; imported by mkht_core and multi_key_hold_tracker_top.
package mkht_pkg;

    // Field widths fixed by the interface
    localparam int KEY_BITS = 16;
    localparam int OP_BITS  = 2;

    // Parameter defaults
    localparam int SLOT_COUNT_DEFAULT = 4;
    localparam int CODE_BITS_DEFAULT  = 15;

    // Slot contents written by a console press
    localparam logic [KEY_BITS-1:0] FORCE_CODE = 16'hFFFF;

    // Operation codes; the fourth code is unused and does nothing
    typedef enum logic [OP_BITS-1:0] {
        OP_PRESS   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_CLEAR   = 2'd2
    } op_t;

    // One result beat
    typedef struct packed {
        logic changed;
        logic is_down;
        logic went_down;
        logic went_up;
        logic slots_full;
    } result_t;

endpackage

>>> hw/rtl/mkht_core.sv
// Slot table, button flags and the combinational update for one key event.
// Depends on mkht_pkg.
module mkht_core #(
    parameter int SLOT_COUNT = mkht_pkg::SLOT_COUNT_DEFAULT,
    parameter int CODE_BITS  = mkht_pkg::CODE_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [mkht_pkg::OP_BITS-1:0]  op,
    input  logic [mkht_pkg::KEY_BITS-1:0] code_raw,
    output mkht_pkg::result_t             res
);
    import mkht_pkg::*;

    localparam logic [KEY_BITS-1:0] CODE_MASK = KEY_BITS'((32'd1 << CODE_BITS) - 32'd1);

    logic [KEY_BITS-1:0]   held_reg [SLOT_COUNT];
    logic [KEY_BITS-1:0]   held_next [SLOT_COUNT];
    logic                  down_reg, down_next;
    logic                  press_edge_reg, press_edge_next;
    logic                  release_edge_reg, release_edge_next;

    logic [KEY_BITS-1:0]   code;
    logic [SLOT_COUNT-1:0] used_vec;
    logic [SLOT_COUNT-1:0] hit_vec;
    logic [SLOT_COUNT-1:0] open_pick;
    logic [SLOT_COUNT-1:0] match_pick;
    logic                  last_used;
    logic                  changed;
    logic                  full;

    assign code = code_raw & CODE_MASK;

    // Slot status and lowest-index picks
    always_comb
    begin
        logic open_found;
        logic match_found;
        open_found  = 1'b0;
        match_found = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            used_vec[i]   = (held_reg[i] != '0);
            hit_vec[i]    = (held_reg[i] == code);
            open_pick[i]  = !used_vec[i] && !open_found;
            open_found    = open_found || !used_vec[i];
            match_pick[i] = used_vec[i] && hit_vec[i] && !match_found;
            match_found   = match_found || (used_vec[i] && hit_vec[i]);
        end
    end

    // Exactly one slot in use
    assign last_used = (used_vec != '0) &&
                       ((used_vec & (used_vec - SLOT_COUNT'(1))) == '0);

    // Next state for the current event
    always_comb
    begin
        held_next         = held_reg;
        down_next         = down_reg;
        press_edge_next   = press_edge_reg;
        release_edge_next = release_edge_reg;
        changed           = 1'b0;
        full              = 1'b0;
        unique case (op)
            OP_PRESS:
            begin
                if (code == '0)
                begin
                    // console force on
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        held_next[i] = '0;
                    end
                    held_next[0]    = FORCE_CODE;
                    down_next       = 1'b1;
                    press_edge_next = 1'b1;
                    changed         = !down_reg;
                end
                else if (hit_vec != '0)
                begin
                    // already held: no effect
                end
                else if (open_pick == '0)
                begin
                    full = 1'b1;
                end
                else
                begin
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        if (open_pick[i])
                        begin
                            held_next[i] = code;
                        end
                    end
                    down_next       = 1'b1;
                    press_edge_next = 1'b1;
                    changed         = !down_reg;
                end
            end
            OP_RELEASE:
            begin
                if (code == '0)
                begin
                    // console force off
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        held_next[i] = '0;
                    end
                    release_edge_next = 1'b1;
                    down_next         = 1'b0;
                    changed           = down_reg;
                end
                else if (match_pick != '0)
                begin
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        if (match_pick[i])
                        begin
                            held_next[i] = '0;
                        end
                    end
                    release_edge_next = 1'b1;
                    if (last_used)
                    begin
                        down_next = 1'b0;
                    end
                    changed = down_reg && !down_next;
                end
            end
            OP_CLEAR:
            begin
                press_edge_next   = 1'b0;
                release_edge_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // Result after the event
    assign res.changed    = changed;
    assign res.is_down    = down_next;
    assign res.went_down  = press_edge_next;
    assign res.went_up    = release_edge_next;
    assign res.slots_full = full;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                held_reg[i] <= '0;
            end
            down_reg         <= 1'b0;
            press_edge_reg   <= 1'b0;
            release_edge_reg <= 1'b0;
        end
        else if (step)
        begin
            held_reg         <= held_next;
            down_reg         <= down_next;
            press_edge_reg   <= press_edge_next;
            release_edge_reg <= release_edge_next;
        end
    end

    // A held button always owns at least one slot
    a_down_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        down_reg |-> (used_vec != '0))
        else $error("button down with no slot in use");

    // Clearing edges leaves both sticky flags low
    a_clear_edges: assert property (@(posedge clk) disable iff (!rst_n)
        (step && op == OP_CLEAR) |=> (!press_edge_reg && !release_edge_reg))
        else $error("edge flags not cleared");

    // A dropped press only happens with every slot taken
    a_full_only_when_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.slots_full) |-> ((used_vec == '1) && op == OP_PRESS))
        else $error("press dropped while a slot was free");

    // A press that changed the button leaves it down
    a_press_sets_down: assert property (@(posedge clk) disable iff (!rst_n)
        (step && op == OP_PRESS && res.changed) |=> down_reg)
        else $error("press reported change but button is up");

endmodule

>>> hw/rtl/multi_key_hold_tracker_top.sv
// Top level of the multi-key hold tracker: input register, result register, handshake.
// Depends on mkht_pkg and mkht_core.
//
// One logical button held by up to SLOT_COUNT key codes at once. Each input beat
// (press, release or clear edges) yields exactly one result beat, which passes
// through the input register and then the result register before it reaches the
// outputs; a new beat is taken every cycle while the result side keeps up, so
// throughput is one event per clock. The slot compare and lowest-free-slot pick
// are combinational between the input register and the result register. Key codes
// are masked to their low CODE_BITS bits; a masked code of zero forces the button
// on or off. The slot table resets to all free and needs no clearing pass.
module multi_key_hold_tracker_top #(
    parameter int SLOT_COUNT = mkht_pkg::SLOT_COUNT_DEFAULT,
    parameter int CODE_BITS  = mkht_pkg::CODE_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [mkht_pkg::OP_BITS-1:0]  operation,
    input  logic [mkht_pkg::KEY_BITS-1:0] key_code,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          changed,
    output logic                          is_down,
    output logic                          went_down,
    output logic                          went_up,
    output logic                          slots_full
);
    import mkht_pkg::*;

    logic                s1_valid_reg, s1_valid_next;
    logic [OP_BITS-1:0]  s1_op_reg, s1_op_next;
    logic [KEY_BITS-1:0] s1_code_reg, s1_code_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_res_reg, out_res_next;
    result_t             core_res;
    logic                advance;
    logic                step;

    // Stage moves forward when the result register is empty or being drained
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign step     = s1_valid_reg && advance;

    mkht_core #(
        .SLOT_COUNT(SLOT_COUNT),
        .CODE_BITS (CODE_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .op      (s1_op_reg),
        .code_raw(s1_code_reg),
        .res     (core_res)
    );

    // Next values for both stages
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_op_next     = s1_op_reg;
        s1_code_next   = s1_code_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (!in_stall)
        begin
            s1_valid_next = in_valid;
            s1_op_next    = operation;
            s1_code_next  = key_code;
        end
        if (advance)
        begin
            out_valid_next = s1_valid_reg;
            out_res_next   = core_res;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        s1_op_reg   <= s1_op_next;
        s1_code_reg <= s1_code_next;
        out_res_reg <= out_res_next;
    end

    assign out_valid  = out_valid_reg;
    assign changed    = out_res_reg.changed;
    assign is_down    = out_res_reg.is_down;
    assign went_down  = out_res_reg.went_down;
    assign went_up    = out_res_reg.went_up;
    assign slots_full = out_res_reg.slots_full;

endmodule
